/* hdl/icr_pkg.sv */
// Shared constants and types for the impulse contact resolver.
// Used by icr_divider, icr_comp_lane and impulse_contact_resolver_core.
`default_nettype none

package icr_pkg;

  // Number formats
  localparam int COMP_WIDTH = 21;
  localparam int FRAC_BITS  = 12;
  localparam int NUM_COMP   = 3;
  localparam int NUM_VEC    = 4;
  localparam int VEC_W      = NUM_COMP * COMP_WIDTH;
  localparam int IM_W       = 16;
  localparam int MSUM_W     = IM_W + 1;
  localparam int PEN_W      = 20;
  localparam int REST_W     = 13;

  // Closing speed and impulse numerator
  localparam int PROD_W   = 2 * COMP_WIDTH + 1;
  localparam int DOT_W    = PROD_W + 2;
  localparam int NEGDOT_W = DOT_W - 1;
  localparam int ONE_W    = FRAC_BITS + 1;
  localparam int FACT_W   = ((ONE_W > REST_W) ? ONE_W : REST_W) + 1;
  localparam int NL_W     = NEGDOT_W / 2;
  localparam int NH_W     = NEGDOT_W - NL_W;
  localparam int NUM_W    = NEGDOT_W + FACT_W;
  localparam int DIVJ_W   = NUM_W - FRAC_BITS;
  localparam int DIVC_W   = PEN_W + FRAC_BITS;
  localparam int DIV_W    = (DIVJ_W > DIVC_W) ? DIVJ_W : DIVC_W;

  // Per-body scale: quotient times inverse mass, clamped
  localparam int JL_W = DIV_W / 2;
  localparam int JH_W = DIV_W - JL_W;
  localparam int KF_W = DIV_W + IM_W;
  localparam int K_W  = COMP_WIDTH + FRAC_BITS + 2;
  localparam logic [K_W-1:0] SCALE_CAP = K_W'(1) << (K_W - 1);

  // Component update in a lane
  localparam int KL_W  = (K_W + 1) / 2;
  localparam int KH_W  = K_W - KL_W;
  localparam int DF_W  = K_W + COMP_WIDTH;
  localparam int D_W   = COMP_WIDTH + 1;
  localparam logic [D_W-1:0] D_CAP = D_W'(1) << COMP_WIDTH;
  localparam int SUM_W = COMP_WIDTH + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (COMP_WIDTH - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Pipeline depth
  localparam int PRE_STAGES  = 6;
  localparam int POST_STAGES = 2;
  localparam int LANE_STAGES = 3;
  localparam int LAT = PRE_STAGES + DIV_W + POST_STAGES + LANE_STAGES;

  // Item data carried alongside the dividers
  typedef struct packed {
    logic [VEC_W-1:0] vel_a;
    logic [VEC_W-1:0] vel_b;
    logic [VEC_W-1:0] pos_a;
    logic [VEC_W-1:0] pos_b;
    logic [VEC_W-1:0] nrm;
    logic [IM_W-1:0]  ima;
    logic [IM_W-1:0]  imb;
    logic             apply;
    logic             fault;
  } side_t;

  typedef struct packed {
    logic applied;
    logic mass_fault;
  } flags_t;

  typedef struct packed {
    logic [VEC_W-1:0] new_vel_a;
    logic [VEC_W-1:0] new_vel_b;
    logic [VEC_W-1:0] new_pos_a;
    logic [VEC_W-1:0] new_pos_b;
    flags_t           flags;
  } result_t;

endpackage

`default_nettype wire

/* hdl/icr_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on icr_pkg for widths.
`default_nettype none

module icr_divider (
  input  logic                       clk,
  input  logic                       en,
  input  logic [icr_pkg::DIV_W-1:0]  dividend,
  input  logic [icr_pkg::MSUM_W-1:0] divisor,
  output logic [icr_pkg::DIV_W-1:0]  quotient
);

  localparam int W = icr_pkg::DIV_W;
  localparam int R = icr_pkg::MSUM_W;

  logic [R-1:0] rem_r [W];
  logic [W-1:0] dq_r  [W];
  logic [R-1:0] dvs_r [W-1];

  genvar s;
  for (s = 0; s < W; s++) begin : g_stage
    logic [R-1:0] rem_in;
    logic [R-1:0] dvs_in;
    logic [W-1:0] dq_in;
    logic [R:0]   trial;
    logic [R:0]   diff;
    logic         ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign dvs_in = divisor;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign dq_in  = dq_r[s-1];
      assign dvs_in = dvs_r[s-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_in, dq_in[W-1]};
    assign ge    = trial >= {1'b0, dvs_in};
    assign diff  = trial - {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[R-1:0] : trial[R-1:0];
        dq_r[s]  <= {dq_in[W-2:0], ge};
      end
    end

    if (s < W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          dvs_r[s] <= dvs_in;
        end
      end
    end
  end

  assign quotient = dq_r[W-1];

endmodule

`default_nettype wire

/* hdl/icr_comp_lane.sv */
// One component lane: adds or subtracts scale*|n| >> FRAC_BITS, saturated.
// Three register stages; depends on icr_pkg.
`default_nettype none

module icr_comp_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic [icr_pkg::COMP_WIDTH-1:0] v_in,
  input  logic [icr_pkg::COMP_WIDTH-1:0] n_in,
  input  logic [icr_pkg::K_W-1:0]        scale,
  input  logic                           add,
  output logic [icr_pkg::COMP_WIDTH-1:0] res
);

  localparam int CW = icr_pkg::COMP_WIDTH;
  localparam int KL = icr_pkg::KL_W;
  localparam int KH = icr_pkg::KH_W;
  localparam int DF = icr_pkg::DF_W;
  localparam int DW = icr_pkg::D_W;
  localparam int SW = icr_pkg::SUM_W;

  logic signed [CW:0] n_ext;
  logic [CW-1:0]      mag;
  logic               neg;

  logic [KL+CW-1:0]   plo1;
  logic [KH+CW-1:0]   phi1;
  logic [CW-1:0]      v1;
  logic               neg1;

  logic [DF-1:0]      full2;
  logic [DF-1:0]      sh2;
  logic [DW-1:0]      d2;
  logic [CW-1:0]      v2;
  logic               neg2;

  logic signed [SW-1:0] v_ext;
  logic signed [SW-1:0] d_ext;
  logic signed [SW-1:0] sum3;
  logic signed [SW-1:0] sat3;

  // magnitude of the normal component and direction of the change
  assign n_ext = (CW + 1)'(signed'(n_in));
  assign mag   = n_ext[CW] ? CW'(-n_ext) : CW'(n_ext);
  assign neg   = n_ext[CW] ^ ~add;

  // stage 1: two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      plo1 <= scale[KL-1:0] * mag;
      phi1 <= scale[icr_pkg::K_W-1:KL] * mag;
      v1   <= v_in;
      neg1 <= neg;
    end
  end

  // stage 2: combine, drop fraction, clamp past saturation
  assign full2 = (DF'(phi1) << KL) + DF'(plo1);
  assign sh2   = full2 >> icr_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      d2   <= (sh2 > DF'(icr_pkg::D_CAP)) ? icr_pkg::D_CAP : DW'(sh2);
      v2   <= v1;
      neg2 <= neg1;
    end
  end

  // stage 3: apply and saturate
  assign v_ext = SW'(signed'(v2));
  assign d_ext = signed'(SW'(d2));
  assign sum3  = neg2 ? (v_ext - d_ext) : (v_ext + d_ext);

  always_comb begin
    if (sum3 > icr_pkg::SAT_HI) begin
      sat3 = icr_pkg::SAT_HI;
    end else if (sum3 < icr_pkg::SAT_LO) begin
      sat3 = icr_pkg::SAT_LO;
    end else begin
      sat3 = sum3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= sat3[CW-1:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/impulse_contact_resolver_core.sv */
// Impulse contact resolver: one contact per beat, fully pipelined.
// Depth: 57 stages plus output register, from input beat to result valid.
// Throughput: one beat per cycle unless skid is full; two 46-stage dividers set depth.
// A skid register behind the output keeps taking one more beat while the output stalls.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// Depends on icr_pkg, icr_divider and icr_comp_lane.
`default_nettype none

module impulse_contact_resolver_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [icr_pkg::VEC_W-1:0]      vel_a,
  input  logic [icr_pkg::VEC_W-1:0]      vel_b,
  input  logic [icr_pkg::VEC_W-1:0]      pos_a,
  input  logic [icr_pkg::VEC_W-1:0]      pos_b,
  input  logic [icr_pkg::IM_W-1:0]       inv_mass_a,
  input  logic [icr_pkg::IM_W-1:0]       inv_mass_b,
  input  logic [icr_pkg::VEC_W-1:0]      contact_normal,
  input  logic [icr_pkg::PEN_W-1:0]      penetration,
  input  logic [icr_pkg::REST_W-1:0]     restitution,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [icr_pkg::VEC_W-1:0]      new_vel_a,
  output logic [icr_pkg::VEC_W-1:0]      new_vel_b,
  output logic [icr_pkg::VEC_W-1:0]      new_pos_a,
  output logic [icr_pkg::VEC_W-1:0]      new_pos_b,
  output logic                           applied,
  output logic                           mass_fault
);

  localparam int CW    = icr_pkg::COMP_WIDTH;
  localparam int NC    = icr_pkg::NUM_COMP;
  localparam int NV    = icr_pkg::NUM_VEC;
  localparam int DW    = icr_pkg::DIV_W;
  localparam int FB    = icr_pkg::FRAC_BITS;
  localparam int LAT   = icr_pkg::LAT;
  localparam int H_IDX = icr_pkg::PRE_STAGES + DW + 1;
  localparam logic [icr_pkg::FACT_W-1:0] ONE_FX = icr_pkg::FACT_W'(1) << FB;

  logic           adv;
  logic [LAT-1:0] vld;
  logic           skid_valid;

  // valid bits of the whole pipeline
  assign adv      = ~skid_valid;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage A: capture beat
  icr_pkg::side_t                   side_a;
  logic [icr_pkg::PEN_W-1:0]        pen_a;
  logic [icr_pkg::REST_W-1:0]       rest_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_a.vel_a <= vel_a;
      side_a.vel_b <= vel_b;
      side_a.pos_a <= pos_a;
      side_a.pos_b <= pos_b;
      side_a.nrm   <= contact_normal;
      side_a.ima   <= inv_mass_a;
      side_a.imb   <= inv_mass_b;
      side_a.apply <= 1'b0;
      side_a.fault <= 1'b0;
      pen_a        <= penetration;
      rest_a       <= restitution;
    end
  end

  // stage B: per-component dot lanes
  logic signed [icr_pkg::PROD_W-1:0] prod_b [NC];
  icr_pkg::side_t                    side_b;
  logic [icr_pkg::PEN_W-1:0]         pen_b;
  logic [icr_pkg::REST_W-1:0]        rest_b;

  genvar c;
  for (c = 0; c < NC; c++) begin : g_dot
    logic signed [CW-1:0] ca;
    logic signed [CW-1:0] cb;
    logic signed [CW-1:0] cn;
    logic signed [CW:0]   dv;
    assign ca = signed'(side_a.vel_a[c*CW +: CW]);
    assign cb = signed'(side_a.vel_b[c*CW +: CW]);
    assign cn = signed'(side_a.nrm[c*CW +: CW]);
    assign dv = (CW + 1)'(ca) - (CW + 1)'(cb);
    always_ff @(posedge clk) begin
      if (adv) begin
        prod_b[c] <= dv * cn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_b <= side_a;
      pen_b  <= pen_a;
      rest_b <= rest_a;
    end
  end

  // stage C: merge lanes into the closing speed, mass sum
  logic signed [icr_pkg::DOT_W-1:0] dot_c;
  logic [icr_pkg::MSUM_W-1:0]       msum_c;
  icr_pkg::side_t                   side_c;
  logic [icr_pkg::PEN_W-1:0]        pen_c;
  logic [icr_pkg::REST_W-1:0]       rest_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_c  <= icr_pkg::DOT_W'(prod_b[0]) + icr_pkg::DOT_W'(prod_b[1])
              + icr_pkg::DOT_W'(prod_b[2]);
      msum_c <= icr_pkg::MSUM_W'(side_b.ima) + icr_pkg::MSUM_W'(side_b.imb);
      side_c <= side_b;
      pen_c  <= pen_b;
      rest_c <= rest_b;
    end
  end

  // stage D: decide, negate closing speed, build 1 + e
  logic                                fault_d_in;
  logic                                apply_d_in;
  icr_pkg::side_t                      side_d_in;
  logic [icr_pkg::NEGDOT_W-1:0]        neg_d;
  logic [icr_pkg::FACT_W-1:0]          fact_d;
  logic [icr_pkg::MSUM_W-1:0]          msum_d;
  icr_pkg::side_t                      side_d;
  logic [icr_pkg::PEN_W-1:0]           pen_d;

  assign fault_d_in = (msum_c == '0);
  assign apply_d_in = ~fault_d_in && (dot_c[icr_pkg::DOT_W-1] || dot_c == '0);

  // item data with the decision flags filled in
  always_comb begin
    side_d_in       = side_c;
    side_d_in.apply = apply_d_in;
    side_d_in.fault = fault_d_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_d        <= apply_d_in ? icr_pkg::NEGDOT_W'(-dot_c) : '0;
      fact_d       <= ONE_FX + icr_pkg::FACT_W'(rest_c);
      msum_d       <= msum_c;
      side_d       <= side_d_in;
      pen_d        <= pen_c;
    end
  end

  // stage E: numerator partial products
  logic [icr_pkg::NL_W+icr_pkg::FACT_W-1:0] pnl_e;
  logic [icr_pkg::NH_W+icr_pkg::FACT_W-1:0] pnh_e;
  logic [icr_pkg::MSUM_W-1:0]               msum_e;
  icr_pkg::side_t                           side_e;
  logic [icr_pkg::PEN_W-1:0]                pen_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      pnl_e  <= neg_d[icr_pkg::NL_W-1:0] * fact_d;
      pnh_e  <= neg_d[icr_pkg::NEGDOT_W-1:icr_pkg::NL_W] * fact_d;
      msum_e <= msum_d;
      side_e <= side_d;
      pen_e  <= pen_d;
    end
  end

  // stage F: divider operands
  logic [icr_pkg::NUM_W-1:0]  num_e;
  logic [DW-1:0]              jdiv_f;
  logic [DW-1:0]              cdiv_f;
  logic [icr_pkg::MSUM_W-1:0] msum_f;
  icr_pkg::side_t             side_f;

  assign num_e = (icr_pkg::NUM_W'(pnh_e) << icr_pkg::NL_W) + icr_pkg::NUM_W'(pnl_e);

  always_ff @(posedge clk) begin
    if (adv) begin
      jdiv_f <= DW'(num_e >> FB);
      cdiv_f <= DW'(pen_e) << FB;
      msum_f <= msum_e;
      side_f <= side_e;
    end
  end

  // impulse and correction quotients
  logic [DW-1:0] j_q;
  logic [DW-1:0] c_q;

  icr_divider u_div_j (
    .clk      (clk),
    .en       (adv),
    .dividend (jdiv_f),
    .divisor  (msum_f),
    .quotient (j_q)
  );

  icr_divider u_div_c (
    .clk      (clk),
    .en       (adv),
    .dividend (cdiv_f),
    .divisor  (msum_f),
    .quotient (c_q)
  );

  // item data alongside the dividers
  icr_pkg::side_t side_dly [DW];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dly[0] <= side_f;
      for (int i = 1; i < DW; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  // stage G: per-body scale partial products (vel_a, vel_b, pos_a, pos_b)
  logic [DW-1:0]                            qsel [NV];
  logic [icr_pkg::IM_W-1:0]                 msel [NV];
  logic [icr_pkg::JL_W+icr_pkg::IM_W-1:0]   kpl_g [NV];
  logic [icr_pkg::JH_W+icr_pkg::IM_W-1:0]   kph_g [NV];
  icr_pkg::side_t                           side_g;

  assign qsel[0] = j_q;
  assign qsel[1] = j_q;
  assign qsel[2] = c_q;
  assign qsel[3] = c_q;
  assign msel[0] = side_dly[DW-1].ima;
  assign msel[1] = side_dly[DW-1].imb;
  assign msel[2] = side_dly[DW-1].ima;
  assign msel[3] = side_dly[DW-1].imb;

  // stage H: combine, drop fraction, clamp, zero when not applied
  logic [icr_pkg::K_W-1:0] k_h [NV];
  icr_pkg::side_t          side_h;

  genvar b;
  for (b = 0; b < NV; b++) begin : g_scale
    logic [icr_pkg::KF_W-1:0] kfull;
    logic [icr_pkg::KF_W-1:0] ksh;

    always_ff @(posedge clk) begin
      if (adv) begin
        kpl_g[b] <= qsel[b][icr_pkg::JL_W-1:0] * msel[b];
        kph_g[b] <= qsel[b][DW-1:icr_pkg::JL_W] * msel[b];
      end
    end

    assign kfull = (icr_pkg::KF_W'(kph_g[b]) << icr_pkg::JL_W) + icr_pkg::KF_W'(kpl_g[b]);
    assign ksh   = kfull >> FB;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!side_g.apply) begin
          k_h[b] <= '0;
        end else if (ksh > icr_pkg::KF_W'(icr_pkg::SCALE_CAP)) begin
          k_h[b] <= icr_pkg::SCALE_CAP;
        end else begin
          k_h[b] <= icr_pkg::K_W'(ksh);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_g <= side_dly[DW-1];
      side_h <= side_g;
    end
  end

  // component lanes
  logic [icr_pkg::VEC_W-1:0] h_vec [NV];
  wire  [icr_pkg::VEC_W-1:0] lane_vec [NV];

  assign h_vec[0] = side_h.vel_a;
  assign h_vec[1] = side_h.vel_b;
  assign h_vec[2] = side_h.pos_a;
  assign h_vec[3] = side_h.pos_b;

  for (b = 0; b < NV; b++) begin : g_vec
    for (c = 0; c < NC; c++) begin : g_comp
      icr_comp_lane u_lane (
        .clk   (clk),
        .en    (adv),
        .v_in  (h_vec[b][c*CW +: CW]),
        .n_in  (side_h.nrm[c*CW +: CW]),
        .scale (k_h[b]),
        .add   ((b == 0) || (b == 2)),
        .res   (lane_vec[b][c*CW +: CW])
      );
    end
  end

  // flags follow the lanes
  icr_pkg::flags_t flg_l [icr_pkg::LANE_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      flg_l[0].applied    <= side_h.apply;
      flg_l[0].mass_fault <= side_h.fault;
      for (int i = 1; i < icr_pkg::LANE_STAGES; i++) begin
        flg_l[i] <= flg_l[i-1];
      end
    end
  end

  // output register and skid register
  icr_pkg::result_t pl_data;
  icr_pkg::result_t out_q;
  icr_pkg::result_t skid_q;

  assign pl_data.new_vel_a = lane_vec[0];
  assign pl_data.new_vel_b = lane_vec[1];
  assign pl_data.new_pos_a = lane_vec[2];
  assign pl_data.new_pos_b = lane_vec[3];
  assign pl_data.flags     = flg_l[icr_pkg::LANE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= vld[LAT-1];
    end else if (vld[LAT-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_q <= skid_q;
      end
    end else if (!out_valid || out_ready) begin
      out_q <= pl_data;
    end else begin
      skid_q <= pl_data;
    end
  end

  assign new_vel_a  = out_q.new_vel_a;
  assign new_vel_b  = out_q.new_vel_b;
  assign new_pos_a  = out_q.new_pos_a;
  assign new_pos_b  = out_q.new_pos_b;
  assign applied    = out_q.flags.applied;
  assign mass_fault = out_q.flags.mass_fault;

  // checks
  a_fault_not_applied: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(applied && mass_fault))
    else $error("fault and applied both set");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full with output empty");

  a_no_apply_zero_scale: assert property (@(posedge clk) disable iff (rst)
    (vld[H_IDX] && !side_h.apply) |->
      (k_h[0] == '0 && k_h[1] == '0 && k_h[2] == '0 && k_h[3] == '0))
    else $error("nonzero scale without impulse");

endmodule

`default_nettype wire

/* test/icr_contact_checker.sv */
// Contact checker: watches both channels of impulse_contact_resolver_core,
// predicts each result from the accepted contact and compares field by field.
// Depends on icr_pkg for widths.
`default_nettype none

module icr_contact_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [icr_pkg::VEC_W-1:0]      vel_a,
  input  logic [icr_pkg::VEC_W-1:0]      vel_b,
  input  logic [icr_pkg::VEC_W-1:0]      pos_a,
  input  logic [icr_pkg::VEC_W-1:0]      pos_b,
  input  logic [icr_pkg::IM_W-1:0]       inv_mass_a,
  input  logic [icr_pkg::IM_W-1:0]       inv_mass_b,
  input  logic [icr_pkg::VEC_W-1:0]      contact_normal,
  input  logic [icr_pkg::PEN_W-1:0]      penetration,
  input  logic [icr_pkg::REST_W-1:0]     restitution,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [icr_pkg::VEC_W-1:0]      new_vel_a,
  input  logic [icr_pkg::VEC_W-1:0]      new_vel_b,
  input  logic [icr_pkg::VEC_W-1:0]      new_pos_a,
  input  logic [icr_pkg::VEC_W-1:0]      new_pos_b,
  input  logic                           applied,
  input  logic                           mass_fault,
  output int                             fail_count,
  output int                             pending_results
);
  import icr_pkg::*;

  localparam logic signed [127:0] CMAX = (128'sd1 <<< (COMP_WIDTH - 1)) - 1;
  localparam logic signed [127:0] CMIN = -(128'sd1 <<< (COMP_WIDTH - 1));
  localparam logic [127:0] KCAP = 128'd1 << (COMP_WIDTH + FRAC_BITS + 1);

  result_t resolved_q[$];

  function automatic logic signed [127:0] comp_of(logic [VEC_W-1:0] v, int i);
    logic signed [COMP_WIDTH-1:0] c;
    c = v[i*COMP_WIDTH +: COMP_WIDTH];
    return 128'(c);
  endfunction

  // v +/- k*n per component, truncated towards zero, saturated
  function automatic logic [VEC_W-1:0] nudge(logic [VEC_W-1:0] v, logic [VEC_W-1:0] n,
                                             logic [127:0] k, bit add);
    logic [VEC_W-1:0] r;
    logic signed [127:0] nc, d, s;
    logic [127:0] mag;
    r = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      nc = comp_of(n, i);
      mag = nc < 0 ? -nc : nc;
      d = (k * mag) >> FRAC_BITS;
      if (nc < 0) d = -d;
      if (!add) d = -d;
      s = comp_of(v, i) + d;
      if (s > CMAX) s = CMAX;
      if (s < CMIN) s = CMIN;
      r[i*COMP_WIDTH +: COMP_WIDTH] = s[COMP_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic [127:0] body_k(logic [127:0] s, logic [127:0] m);
    logic [127:0] k;
    k = (s * m) >> FRAC_BITS;
    return k > KCAP ? KCAP : k;
  endfunction

  function automatic result_t resolve_contact();
    result_t r;
    logic [127:0] msum, num, j, c;
    logic signed [127:0] dot;
    r.new_vel_a = vel_a;
    r.new_vel_b = vel_b;
    r.new_pos_a = pos_a;
    r.new_pos_b = pos_b;
    r.flags = '0;
    msum = inv_mass_a + inv_mass_b;
    if (msum == 0) begin
      r.flags.mass_fault = 1'b1;
      return r;
    end
    dot = 0;
    for (int i = 0; i < NUM_COMP; i++)
      dot += (comp_of(vel_a, i) - comp_of(vel_b, i)) * comp_of(contact_normal, i);
    if (dot > 0) return r;
    num = (-dot) * ((128'd1 << FRAC_BITS) + restitution);
    j = num / (msum << FRAC_BITS);
    c = (128'(penetration) << FRAC_BITS) / msum;
    r.new_vel_a = nudge(vel_a, contact_normal, body_k(j, inv_mass_a), 1'b1);
    r.new_vel_b = nudge(vel_b, contact_normal, body_k(j, inv_mass_b), 1'b0);
    r.new_pos_a = nudge(pos_a, contact_normal, body_k(c, inv_mass_a), 1'b1);
    r.new_pos_b = nudge(pos_b, contact_normal, body_k(c, inv_mass_b), 1'b0);
    r.flags.applied = 1'b1;
    return r;
  endfunction

  assign pending_results = resolved_q.size();

  initial fail_count = 0;

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    result_t e;
    if (!rst) begin
      if (in_valid && in_ready) resolved_q.push_back(resolve_contact());
      if (out_valid && out_ready) begin
        if (resolved_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = resolved_q.pop_front();
          if (new_vel_a !== e.new_vel_a) begin
            $error("new_vel_a exp %h got %h", e.new_vel_a, new_vel_a); fail_count++;
          end
          if (new_vel_b !== e.new_vel_b) begin
            $error("new_vel_b exp %h got %h", e.new_vel_b, new_vel_b); fail_count++;
          end
          if (new_pos_a !== e.new_pos_a) begin
            $error("new_pos_a exp %h got %h", e.new_pos_a, new_pos_a); fail_count++;
          end
          if (new_pos_b !== e.new_pos_b) begin
            $error("new_pos_b exp %h got %h", e.new_pos_b, new_pos_b); fail_count++;
          end
          if (applied !== e.flags.applied) begin
            $error("applied exp %b got %b", e.flags.applied, applied); fail_count++;
          end
          if (mass_fault !== e.flags.mass_fault) begin
            $error("mass_fault exp %b got %b", e.flags.mass_fault, mass_fault); fail_count++;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

/* test/tb_impulse_contact_resolver_core.sv */
// Testbench top for impulse_contact_resolver_core: drives directed and random
// contacts with bursty input and stalling output, verdict from icr_contact_checker.
// Depends on icr_pkg, the core and icr_contact_checker.
`default_nettype none

module tb_impulse_contact_resolver_core;
  import icr_pkg::*;

  localparam int N_RANDOM = 1330;
  localparam logic [COMP_WIDTH-1:0] ONE = COMP_WIDTH'(1) << FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  logic [VEC_W-1:0] vel_a = '0, vel_b = '0, pos_a = '0, pos_b = '0, contact_normal = '0;
  logic [IM_W-1:0] inv_mass_a = '0, inv_mass_b = '0;
  logic [PEN_W-1:0] penetration = '0;
  logic [REST_W-1:0] restitution = '0;
  logic [VEC_W-1:0] new_vel_a, new_vel_b, new_pos_a, new_pos_b;
  logic applied, mass_fault;
  int fail_count, pending_results;
  int gap_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  impulse_contact_resolver_core u_top (.*);

  icr_contact_checker u_chk (.*);

  // Receiver: stall pattern switching between free-running and patchy modes
  always @(negedge clk) begin
    int mode;
    mode = ($urandom_range(0, 199) == 0) ? 1 : 0;
    if ($urandom_range(0, 3) == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 1) == 1) || (($time / 5000) % 2 == 0) || mode;
  end

  function automatic logic [VEC_W-1:0] rand_vec(int kind);
    logic [VEC_W-1:0] v;
    logic signed [COMP_WIDTH-1:0] c;
    v = VEC_W'({$urandom, $urandom});
    for (int i = 0; i < NUM_COMP; i++) begin
      case (kind)
        0: c = COMP_WIDTH'(int'($urandom_range(0, 2 * 8192)) - 8192);
        1: c = COMP_WIDTH'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, ONE)));
        default: c = v[i*COMP_WIDTH +: COMP_WIDTH];
      endcase
      v[i*COMP_WIDTH +: COMP_WIDTH] = c;
    end
    return v;
  endfunction

  // One input beat; holds the payload until accepted
  task automatic send_contact(logic [VEC_W-1:0] va, logic [VEC_W-1:0] vb,
                              logic [VEC_W-1:0] pa, logic [VEC_W-1:0] pb,
                              logic [IM_W-1:0] ma, logic [IM_W-1:0] mb,
                              logic [VEC_W-1:0] n, logic [PEN_W-1:0] pen,
                              logic [REST_W-1:0] rest);
    vel_a <= va; vel_b <= vb; pos_a <= pa; pos_b <= pb;
    inv_mass_a <= ma; inv_mass_b <= mb; contact_normal <= n;
    penetration <= pen; restitution <= rest;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    // burst gaps between beats
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(1, 6);
    end
  endtask

  task automatic random_contact();
    int kv, kn;
    logic [IM_W-1:0] ma, mb;
    logic [REST_W-1:0] rest;
    kv = $urandom_range(0, 2);
    kn = $urandom_range(0, 9) < 7 ? 1 : 2;
    ma = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(0, 9) < 7 ?
         $urandom_range(1, 3 * 4096) : $urandom);
    mb = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(0, 9) < 7 ?
         $urandom_range(1, 3 * 4096) : $urandom);
    rest = $urandom_range(0, 9) == 0 ? REST_W'($urandom) : REST_W'($urandom_range(0, 4096));
    send_contact(rand_vec(kv), rand_vec(kv), rand_vec(2), rand_vec(2), ma, mb,
                 rand_vec(kn), PEN_W'($urandom), rest);
  endtask

  localparam logic [VEC_W-1:0] NX = VEC_W'(ONE);
  localparam logic [VEC_W-1:0] ALL1 = '1;
  localparam logic [VEC_W-1:0] VMAX = {3{1'b0, {(COMP_WIDTH-1){1'b1}}}};
  localparam logic [VEC_W-1:0] VMIN = {3{1'b1, {(COMP_WIDTH-1){1'b0}}}};

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: approach, separate, zero speed, fault, extremes
    send_contact(VEC_W'(ONE), '0, '0, '0, 16'h1000, 16'h1000, NX, 20'h1000, 13'h1000);
    send_contact('0, VEC_W'(ONE), '0, '0, 16'h1000, 16'h1000, NX, 20'h1000, 13'h0800);
    send_contact('0, '0, '0, '0, 16'h1000, 16'h1000, NX, 20'h00800, 13'h0);
    send_contact(VEC_W'(ONE), '0, '0, '0, 16'h0, 16'h0, NX, 20'h1000, 13'h1000);
    send_contact('0, VEC_W'(ONE), ALL1, ALL1, 16'h0, 16'h0, NX, 20'hFFFFF, 13'h1FFF);
    send_contact(VMIN, VMAX, VMAX, VMIN, 16'hFFFF, 16'hFFFF, ALL1, 20'hFFFFF, 13'h1FFF);
    send_contact(VMAX, VMIN, VMIN, VMAX, 16'h0001, 16'h0, VMAX, 20'hFFFFF, 13'h1000);
    send_contact(VMIN, VMAX, VMIN, VMAX, 16'h0, 16'hFFFF, VMIN, 20'h00001, 13'h0);
    send_contact(ALL1, '0, ALL1, '0, 16'hFFFF, 16'h0001, VMIN, 20'h0, 13'h1FFF);
    send_contact('0, ALL1, '0, ALL1, 16'h0001, 16'h0001, VMAX, 20'hFFFFF, 13'h1000);
    send_contact(VMIN, '0, '0, '0, 16'h8000, 16'h8000, VMAX, 20'h80000, 13'h1000);
    send_contact(VMAX, '0, VMAX, VMIN, 16'h1000, 16'h0, ALL1, 20'h7FFFF, 13'h0FFF);
    // hold off until the pipeline drains
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) random_contact();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire
